[src/lcks_pkg.sv]
// Package for the lightweight cipher key schedule.
// Holds the key-half widths, the key-half pair type and the 4-bit S-box.
// No dependencies.
`default_nettype none

package lcks_pkg;

    localparam int HALF_W = 40;
    localparam int NIB_W  = 4;
    localparam int APB_DW = 64;
    localparam int APB_AW = 4;

    // Register offsets on the configuration port (8-byte stride).
    localparam logic REG_KEY_FIRST  = 1'b0;
    localparam logic REG_KEY_SECOND = 1'b1;

    typedef logic [HALF_W-1:0] t_half;
    typedef logic [NIB_W-1:0]  t_nib;

    typedef struct packed {
        t_half first_half;
        t_half second_half;
    } t_halves;

    localparam t_nib SBOX [16] = '{
        4'd0, 4'd8, 4'd6, 4'd13, 4'd5, 4'd15, 4'd7, 4'd12,
        4'd4, 4'd14, 4'd2, 4'd3, 4'd9, 4'd1, 4'd11, 4'd10
    };

    // Reverses the order of the four nibble bits.
    function automatic t_nib rev4(input t_nib v);
        return {v[0], v[1], v[2], v[3]};
    endfunction

endpackage

`default_nettype wire

[src/lcks_if.sv]
// Handshake channel interfaces for the key schedule: round request and key result.
// Depends on lcks_pkg for the key-half width.
`default_nettype none

interface lcks_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface lcks_rsp_if;
    logic                 valid;
    logic                 ready;
    lcks_pkg::t_half      first_half_out;
    lcks_pkg::t_half      second_half_out;

    modport source (output valid, output first_half_out, output second_half_out, input ready);
    modport sink   (input valid, input first_half_out, input second_half_out, output ready);
endinterface

`default_nettype wire

[src/lcks_round.sv]
// One key schedule round: nibble mix through the S-box and a 4-bit shift of both halves.
// Depends on lcks_pkg.
`default_nettype none

module lcks_round (
    input  lcks_pkg::t_halves i_cur,
    output lcks_pkg::t_halves o_nxt
);

    lcks_pkg::t_nib w_f;
    lcks_pkg::t_nib w_s;
    lcks_pkg::t_nib w_x;
    lcks_pkg::t_nib w_y;
    lcks_pkg::t_nib w_g;

    always_comb begin
        w_f = i_cur.first_half[lcks_pkg::HALF_W-1 -: lcks_pkg::NIB_W];
        w_s = i_cur.second_half[lcks_pkg::HALF_W-1 -: lcks_pkg::NIB_W];
        // Rotate right by two, then mix in the first-half nibble.
        w_x = {w_s[1:0], w_s[3:2]} ^ w_f;
        // The S-box is indexed with the nibble bits in reversed order.
        w_y = lcks_pkg::rev4(lcks_pkg::SBOX[lcks_pkg::rev4(w_x)]);
        // Rotate right by three.
        w_g = {w_f[2:0], w_f[3]} ^ w_y;

        o_nxt.first_half  = {i_cur.first_half[lcks_pkg::HALF_W-lcks_pkg::NIB_W-1:0], w_g};
        o_nxt.second_half = {i_cur.second_half[lcks_pkg::HALF_W-lcks_pkg::NIB_W-1:0], w_y};
    end

endmodule

`default_nettype wire

[src/lightweight_cipher_key_schedule.sv]
// Top level of the 80-bit key schedule round engine: key registers, state and handshakes.
// Depends on lcks_pkg, lcks_if.sv and lcks_round.
`default_nettype none

// Channel   Direction  Handshake        Payload
// i_req     in         valid / ready    restart (1)
// o_rsp     out        valid / ready    first_half_out (40), second_half_out (40)
// APB       in         psel / penable   key_first_half @ 0x0, key_second_half @ 0x8
//
// Each accepted request advances the schedule by exactly one round, and the
// result is registered, so it appears in the cycle after the request is taken.
// A new request is taken every cycle as long as the result register is empty
// or its content is being taken in the same cycle; the single round is short
// enough to sit between the state register and that result register.
// The synchronous active-low reset clears the key registers, the running
// halves, the started flag and the result valid flag.
// When the result side stalls, ready drops and the held result stays put.

module lightweight_cipher_key_schedule (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    lcks_req_if.sink                       i_req,
    lcks_rsp_if.source                     o_rsp,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [lcks_pkg::APB_AW-1:0] paddr,
    input  wire logic [lcks_pkg::APB_DW-1:0] pwdata,
    output logic      [lcks_pkg::APB_DW-1:0] prdata,
    output logic                           pready
);

    // Key registers written through the configuration port.
    lcks_pkg::t_half   r_key_first;
    lcks_pkg::t_half   r_key_second;

    // Running key halves; they double as the result register.
    lcks_pkg::t_halves r_halves;
    lcks_pkg::t_halves n_halves;
    logic              r_started;
    logic              r_rsp_valid;

    lcks_pkg::t_halves w_round_in;
    logic              w_req_take;
    logic              w_cfg_wr;
    logic              w_reg_sel;

    // Configuration port. Only paddr[3] is decoded, so every write lands on
    // one of the two key registers; the low address bits alias.
    assign pready    = 1'b1;
    assign w_reg_sel = paddr[3];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        case (w_reg_sel)
            lcks_pkg::REG_KEY_FIRST:  prdata[lcks_pkg::HALF_W-1:0] = r_key_first;
            lcks_pkg::REG_KEY_SECOND: prdata[lcks_pkg::HALF_W-1:0] = r_key_second;
            default:                  prdata = '0;
        endcase
    end

    // The request side is open whenever the result register is free or is
    // being emptied in this very cycle.
    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign w_req_take  = i_req.valid && i_req.ready;

    // The first round after reset, and any round that asks for a restart,
    // starts from the key registers instead of the running halves.
    always_comb begin
        if (!r_started || i_req.restart) begin
            w_round_in.first_half  = r_key_first;
            w_round_in.second_half = r_key_second;
        end else begin
            w_round_in = r_halves;
        end
    end

    lcks_round u_round (
        .i_cur (w_round_in),
        .o_nxt (n_halves)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_first  <= '0;
            r_key_second <= '0;
            r_halves     <= '0;
            r_started    <= 1'b0;
            r_rsp_valid  <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                case (w_reg_sel)
                    lcks_pkg::REG_KEY_FIRST:  r_key_first  <= pwdata[lcks_pkg::HALF_W-1:0];
                    lcks_pkg::REG_KEY_SECOND: r_key_second <= pwdata[lcks_pkg::HALF_W-1:0];
                    default:                  r_key_first  <= r_key_first;
                endcase
            end
            if (w_req_take) begin
                r_halves    <= n_halves;
                r_started   <= 1'b1;
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid           = r_rsp_valid;
    assign o_rsp.first_half_out  = r_halves.first_half;
    assign o_rsp.second_half_out = r_halves.second_half;

endmodule

`default_nettype wire
